// ===== rtl/refcounted_handle_allocator_top_assert.svh =====
// Assertion macros shared by the handle allocator RTL.
`ifndef REFCOUNTED_HANDLE_ALLOCATOR_TOP_ASSERT_SVH
`define REFCOUNTED_HANDLE_ALLOCATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked outside reset only.
`define RHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define RHA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RHA_ASSERT(lbl, prop, msg)
`define RHA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/rha_pkg.sv =====
// Package: constants, codes and word types of the handle allocator.
package rha_pkg;

  localparam int CELLS      = 1024;
  localparam int COUNT_BITS = 8;
  localparam int HANDLE_W   = $clog2(CELLS);
  localparam int USED_W     = $clog2(CELLS + 1);

  localparam logic [HANDLE_W-1:0]   HEAD_INIT  = HANDLE_W'(CELLS - 3);
  localparam logic [HANDLE_W-1:0]   RSV_LOW    = HANDLE_W'(CELLS - 2);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [USED_W-1:0]     USED_INIT  = USED_W'(2);

  // Operation codes; codes above query behave as query
  typedef enum logic [2:0] {
    KIND_ALLOC  = 3'd0,
    KIND_INC    = 3'd1,
    KIND_DEC    = 3'd2,
    KIND_IMMUNE = 3'd3,
    KIND_QUERY  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    STS_OK           = 3'd0,
    STS_OUT_OF_CELLS = 3'd1,
    STS_FREED        = 3'd2,
    STS_ALREADY_FREE = 3'd3,
    STS_IGNORED      = 3'd4
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [2:0]          kind;
    logic [HANDLE_W-1:0] handle;
  } in_word_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]   result_handle;
    logic [COUNT_BITS-1:0] count_after;
    logic [2:0]            status;
    logic [USED_W-1:0]     used_cells;
  } out_word_t;

  // One entry of the cell memory
  typedef struct packed {
    logic                  free;
    logic [COUNT_BITS-1:0] count;
  } cell_word_t;

  // Free list commands, issued in the execute cycle
  typedef struct packed {
    logic                pop;
    logic                push;
    logic [HANDLE_W-1:0] push_handle;
  } fl_cmd_t;

  // Free list status
  typedef struct packed {
    logic                empty;
    logic [HANDLE_W-1:0] head;
    logic [HANDLE_W-1:0] fresh;
  } fl_stat_t;

endpackage

// ===== rtl/refcounted_handle_allocator_top.sv =====
// Handle allocator with LIFO free list and saturating reference counts.
//
// Usage:
//   Input channel in_valid_i / in_stall_o carries one word {kind, handle}:
//   allocate, increase, decrease, make immune or query. Output channel
//   out_valid_o / out_stall_i returns one word per input word with the
//   handle, the count after the operation, a status and the number of
//   allocated cells. A word moves at an edge with valid high, stall low.
//   cfg_we_i / cfg_wdata_i set the lock bit; write it only when idle.
// Operation:
//   The accept edge reads the cell memory and the free list link; the
//   next edge writes both back and loads the output register. A new
//   input word is taken only after that read-modify-write on the cell
//   memory is done.
// Reset:
//   Asynchronous, active low. The free list and counts start valid at
//   once with no clearing pass; a word can be taken right after reset.
// Stall:
//   The output register holds its word while out_stall_i is high; a new
//   input word is taken only when that register is free by the next edge.
`include "refcounted_handle_allocator_top_assert.svh"
module refcounted_handle_allocator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rha_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rha_pkg::out_word_t out_word_o
);
  import rha_pkg::*;

  state_e                state_q, state_d;
  in_word_t              op_q;
  logic                  lock_q;
  logic [USED_W-1:0]     used_q, used_d;
  logic                  out_valid_q;
  out_word_t             out_word_q, out_word_d;
  logic                  accept;

  logic                  cell_we;
  logic [HANDLE_W-1:0]   cell_waddr;
  cell_word_t            cell_wdata;
  logic [COUNT_BITS:0]   cell_rdata;
  cell_word_t            cell_rd;

  fl_cmd_t               fl_cmd;
  fl_stat_t              fl_stat;

  logic                  reserved;
  logic                  is_free;
  logic [COUNT_BITS-1:0] cnt_new;

  // Input handshake
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // Cell memory: free flag and count per handle
  rha_ram #(
    .WIDTH (COUNT_BITS + 1),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (accept),
    .raddr_i (in_word_i.handle),
    .rdata_o (cell_rdata)
  );

  assign cell_rd = cell_word_t'(cell_rdata);

  rha_free_list u_free_list (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (accept),
    .cmd_i   (fl_cmd),
    .stat_o  (fl_stat)
  );

  // Cell classification for the word in execute
  assign reserved = (op_q.handle == '0) || (op_q.handle >= RSV_LOW);
  assign is_free  = (op_q.handle <= fl_stat.fresh) || cell_rd.free;

  // Next state, memory writes and result word
  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    cell_we    = 1'b0;
    cell_waddr = op_q.handle;
    cell_wdata = '{free: 1'b0, count: cell_rd.count};
    fl_cmd     = '0;
    cnt_new    = cell_rd.count;
    out_word_d = out_word_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d                  = ST_IDLE;
        out_word_d.result_handle = op_q.handle;
        out_word_d.count_after   = '0;
        out_word_d.status        = STS_OK;
        if (op_q.kind == KIND_ALLOC) begin
          if (fl_stat.empty) begin
            out_word_d.result_handle = '0;
            out_word_d.status        = STS_OUT_OF_CELLS;
          end else begin
            out_word_d.result_handle = fl_stat.head;
            fl_cmd.pop               = 1'b1;
            cell_we                  = 1'b1;
            cell_waddr               = fl_stat.head;
            cell_wdata               = '{free: 1'b0, count: '0};
            used_d                   = used_q + USED_W'(1);
          end
        end else if (reserved) begin
          out_word_d.status = STS_IGNORED;
        end else if (is_free) begin
          out_word_d.status = STS_ALREADY_FREE;
        end else begin
          case (op_q.kind)
            KIND_INC: begin
              if (lock_q) begin
                out_word_d.status = STS_IGNORED;
              end else if (cell_rd.count != COUNT_MAX) begin
                cnt_new = cell_rd.count + COUNT_BITS'(1);
              end
              cell_we    = 1'b1;
              cell_wdata = '{free: 1'b0, count: cnt_new};
              out_word_d.count_after = cnt_new;
            end
            KIND_DEC: begin
              if (cell_rd.count != '0 && cell_rd.count != COUNT_MAX) begin
                cnt_new = cell_rd.count - COUNT_BITS'(1);
              end
              cell_we    = 1'b1;
              cell_wdata = '{free: 1'b0, count: cnt_new};
              out_word_d.count_after = cnt_new;
              // Count hit zero while unlocked: return cell to the list
              if (cnt_new == '0 && !lock_q) begin
                cell_wdata         = '{free: 1'b1, count: '0};
                fl_cmd.push        = 1'b1;
                fl_cmd.push_handle = op_q.handle;
                used_d             = used_q - USED_W'(1);
                out_word_d.status  = STS_FREED;
              end
            end
            KIND_IMMUNE: begin
              cell_we    = 1'b1;
              cell_wdata = '{free: 1'b0, count: COUNT_MAX};
              out_word_d.count_after = COUNT_MAX;
            end
            default: begin
              out_word_d.count_after = cell_rd.count;
            end
          endcase
        end
        out_word_d.used_cells = used_d;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= USED_INIT;
      lock_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cfg_we_i) begin
        lock_q <= cfg_wdata_i;
      end
      if (state_q == ST_EXEC) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_word_i;
    end
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `RHA_ASSERT_ALWAYS(a_no_accept_busy, !(state_q == ST_EXEC && accept), "word taken during execute")
  `RHA_ASSERT(a_accept_exec, accept |=> state_q == ST_EXEC, "accepted word not executed")
  `RHA_ASSERT(a_exec_result, state_q == ST_EXEC |=> out_valid_q, "execute gave no result word")
  `RHA_ASSERT(a_used_bound, used_q <= USED_W'(CELLS), "used cell count out of range")

endmodule

// ===== rtl/rha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module rha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rha_free_list.sv =====
// LIFO free list: head register, link memory and a fresh-region pointer.
`include "refcounted_handle_allocator_top_assert.svh"
module rha_free_list (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  rha_pkg::fl_cmd_t cmd_i,
  output rha_pkg::fl_stat_t stat_o
);
  import rha_pkg::*;

  // Handles 1..fresh_q were never allocated: their link is handle minus one
  // and they are free, so the link memory needs no initialization.
  logic [HANDLE_W-1:0] head_q, head_d;
  logic [HANDLE_W-1:0] fresh_q, fresh_d;
  logic [HANDLE_W-1:0] link_rd;
  logic                head_is_fresh;

  rha_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (CELLS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (cmd_i.push_handle),
    .wdata_i (head_q),
    .re_i    (rd_en_i),
    .raddr_i (head_q),
    .rdata_o (link_rd)
  );

  // Next head on pop or push
  always_comb begin
    head_d        = head_q;
    fresh_d       = fresh_q;
    head_is_fresh = (head_q <= fresh_q);
    if (cmd_i.pop) begin
      if (head_is_fresh) begin
        head_d  = head_q - HANDLE_W'(1);
        fresh_d = head_q - HANDLE_W'(1);
      end else begin
        head_d = link_rd;
      end
    end else if (cmd_i.push) begin
      head_d = cmd_i.push_handle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= HEAD_INIT;
      fresh_q <= HEAD_INIT;
    end else begin
      head_q  <= head_d;
      fresh_q <= fresh_d;
    end
  end

  assign stat_o.empty = (head_q == '0);
  assign stat_o.head  = head_q;
  assign stat_o.fresh = fresh_q;

  `RHA_ASSERT(a_no_pop_empty, cmd_i.pop |-> head_q != '0, "pop from empty free list")
  `RHA_ASSERT(a_push_old_cell, cmd_i.push |-> (cmd_i.push_handle > fresh_q && cmd_i.push_handle != '0), "push of a never-allocated handle")
  `RHA_ASSERT(a_no_pop_push, !(cmd_i.pop && cmd_i.push), "pop and push together")
  `RHA_ASSERT(a_fresh_bound, fresh_q <= HEAD_INIT, "fresh pointer above initial head")

endmodule
